[hdl/arpn_pkg.sv]
// ---------------------------------------------------------------------------
// arpn_pkg: shared definitions for the auto-ranging pulse normalizer
// Word types, register indexes, reset values and widths used by all files.
// ---------------------------------------------------------------------------
package arpn_pkg;

  localparam int NUM_CHANNELS = 6;
  localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_VALID_FLOOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SPAN    = 2'd1;

  localparam logic [15:0] LOW_RESET   = 16'd5000;
  localparam logic [15:0] FLOOR_RESET = 16'd500;
  localparam logic [9:0]  SPAN_RESET  = 10'd100;

  // Product of a 16-bit distance and a 10-bit span.
  localparam int MAG_W = 26;
  localparam int CNT_W = $clog2(MAG_W);

  localparam logic [MAG_W-1:0] PCT_POS_LIMIT = MAG_W'(32767);
  localparam logic [MAG_W-1:0] PCT_NEG_LIMIT = MAG_W'(32768);
  localparam logic [15:0]      PCT_MAX_CODE  = 16'h7FFF;
  localparam logic [15:0]      PCT_MIN_CODE  = 16'h8000;

  typedef struct packed {
    logic [2:0]  channel;
    logic [15:0] pulse_width;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         channel_out;
    logic signed [15:0] percent;
    logic               range_invalid;
  } out_word_t;

  // One classified measurement waiting for the divider.
  typedef struct packed {
    logic [2:0]       channel;
    logic             bad;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [15:0]      den;
  } job_t;

endpackage

[hdl/arpn_front.sv]
// ---------------------------------------------------------------------------
// arpn_front: bound tracking and classification
// Holds the configuration and per-channel bounds, updates a known channel's
// bounds on each accepted word and forms the numerator magnitude and divisor.
// ---------------------------------------------------------------------------
module arpn_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [arpn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [arpn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  arpn_pkg::in_word_t             item,
  output logic                           job_valid,
  input  logic                           job_full,
  output arpn_pkg::job_t                 job
);

  logic [15:0] low_bound  [arpn_pkg::NUM_CHANNELS];
  logic [15:0] high_bound [arpn_pkg::NUM_CHANNELS];
  logic [15:0] valid_floor;
  logic [9:0]  out_span;

  logic        a_valid;
  logic [2:0]  a_ch;
  logic [15:0] a_w;
  logic [15:0] a_lo;
  logic [15:0] a_hi;
  logic        a_bad;

  logic                          accept;
  logic                          job_push;
  logic                          in_range;
  logic [arpn_pkg::CH_IDX_W-1:0] idx;
  logic [15:0]                   lo_cur;
  logic [15:0]                   hi_cur;
  logic [15:0]                   lo_new;
  logic [15:0]                   hi_new;
  logic [15:0]                   abs_diff;

  assign job_push  = a_valid && !job_full;
  assign full      = a_valid && job_full;
  assign accept    = push && !full;
  assign job_valid = job_push;

  assign idx      = item.channel[arpn_pkg::CH_IDX_W-1:0];
  assign in_range = 32'(item.channel) < arpn_pkg::NUM_CHANNELS;

  always_comb begin
    lo_cur = low_bound[idx];
    hi_cur = high_bound[idx];
    lo_new = lo_cur;
    hi_new = hi_cur;
    if (item.pulse_width > valid_floor && item.pulse_width < lo_cur) begin
      lo_new = item.pulse_width;
    end
    if (item.pulse_width > hi_cur) begin
      hi_new = item.pulse_width;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_floor <= arpn_pkg::FLOOR_RESET;
      out_span    <= arpn_pkg::SPAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        arpn_pkg::REG_VALID_FLOOR: valid_floor <= cfg_data[15:0];
        arpn_pkg::REG_OUT_SPAN:    out_span    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < arpn_pkg::NUM_CHANNELS; k++) begin
        low_bound[k]  <= arpn_pkg::LOW_RESET;
        high_bound[k] <= 16'd0;
      end
    end else if (accept && in_range) begin
      low_bound[idx]  <= lo_new;
      high_bound[idx] <= hi_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (job_push) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_ch  <= item.channel;
      a_w   <= item.pulse_width;
      a_lo  <= lo_new;
      a_hi  <= hi_new;
      a_bad <= !in_range || !(hi_new > lo_new);
    end
  end

  // The sign of the distance is kept apart so the multiply and the divide
  // both work on magnitudes.
  assign abs_diff = (a_w < a_lo) ? (a_lo - a_w) : (a_w - a_lo);

  always_comb begin
    job.channel = a_ch;
    job.bad     = a_bad;
    job.neg     = a_w < a_lo;
    job.mag     = arpn_pkg::MAG_W'({10'd0, abs_diff} * {16'd0, out_span});
    job.den     = a_hi - a_lo;
  end

endmodule

[hdl/arpn_queue.sv]
// ---------------------------------------------------------------------------
// arpn_queue: two-entry job queue
// Decouples the bound tracker from the divider.
// ---------------------------------------------------------------------------
module arpn_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  arpn_pkg::job_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output arpn_pkg::job_t rd_data,
  output logic           empty
);

  arpn_pkg::job_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

[hdl/arpn_back.sv]
// ---------------------------------------------------------------------------
// arpn_back: divider, saturation and result register
// Divides one job per pass with a one-bit-per-cycle restoring divider and
// holds the finished result until it is popped.
// ---------------------------------------------------------------------------
module arpn_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_empty,
  input  arpn_pkg::job_t      job,
  output logic                job_pop,
  output logic                empty,
  input  logic                pop,
  output arpn_pkg::out_word_t result
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [2:0]                 ch;
  logic                       neg;
  logic                       bad;
  logic [15:0]                den;
  logic [arpn_pkg::MAG_W-1:0] quo;
  logic [15:0]                rem;
  logic [arpn_pkg::CNT_W-1:0] cnt;
  logic                       out_valid;

  logic [16:0] rem_shift;
  logic        fits;
  logic        out_free;
  logic [15:0] pct;

  assign out_free  = !out_valid || pop;
  assign empty     = !out_valid;
  assign job_pop   = (state == S_IDLE) && !job_empty;
  assign rem_shift = {rem, quo[arpn_pkg::MAG_W-1]};
  assign fits      = rem_shift >= {1'b0, den};

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!job_empty) begin
          state_next = job.bad ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        if (cnt == arpn_pkg::CNT_W'(arpn_pkg::MAG_W - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      ch  <= job.channel;
      neg <= job.neg;
      bad <= job.bad;
      den <= job.den;
      quo <= job.mag;
      rem <= 16'd0;
      cnt <= '0;
    end else if (state == S_DIV) begin
      rem <= fits ? 16'(rem_shift - {1'b0, den}) : rem_shift[15:0];
      quo <= {quo[arpn_pkg::MAG_W-2:0], fits};
      cnt <= cnt + arpn_pkg::CNT_W'(1);
    end
  end

  // Truncation toward zero falls out of dividing magnitudes and negating.
  always_comb begin
    if (bad) begin
      pct = 16'd0;
    end else if (neg) begin
      pct = (quo >= arpn_pkg::PCT_NEG_LIMIT) ? arpn_pkg::PCT_MIN_CODE
                                              : 16'(~quo[15:0] + 16'd1);
    end else begin
      pct = (quo > arpn_pkg::PCT_POS_LIMIT) ? arpn_pkg::PCT_MAX_CODE : quo[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      result.channel_out   <= ch;
      result.percent       <= pct;
      result.range_invalid <= bad;
    end
  end

endmodule

[hdl/auto_ranging_pulse_normalizer_unit.sv]
// ---------------------------------------------------------------------------
// auto_ranging_pulse_normalizer_unit: per-channel min/max percent mapping
// Tracks a low and a high bound for each receiver channel and maps every
// measured pulse width onto the bounds as a saturated signed percent.
// ---------------------------------------------------------------------------
//
//   Channel   Ports                            Direction  Handshake
//   -------   -------------------------------  ---------  ------------------
//   input     push, full, item                 in         push && !full
//   result    empty, pop, result               out        pop && !empty
//   config    cfg_we, cfg_index, cfg_data      in         cfg_we, no wait
//
// A word is registered in the bound tracker's stage and moves from there
// into the job queue once the queue has room. The divider then loads a job,
// produces the quotient bits with its one-bit-per-cycle divider and writes
// the result register once that is free; it takes a new job only after it
// has written the last result. A word with an empty or inverted range or an
// unknown channel skips the divide and goes from loading to the result write.
// Reset is synchronous; it restores every low bound to 5000, every high
// bound to zero and the registers to their defaults.
// The job queue holds two words, so the input keeps accepting while the
// divider works and while a finished result waits for pop, until it fills.
//
module auto_ranging_pulse_normalizer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [arpn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arpn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            push,
  output logic                            full,
  input  arpn_pkg::in_word_t              item,
  output logic                            empty,
  input  logic                            pop,
  output arpn_pkg::out_word_t             result
);

  // Jobs flow from the bound tracker through the queue to the divider.
  logic           job_push;
  logic           job_full;
  arpn_pkg::job_t job_in;
  logic           job_pop;
  logic           job_empty;
  arpn_pkg::job_t job_out;

  // The front end updates the bounds as each word is accepted, so the next
  // word of the same channel already sees the new bounds.
  arpn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .item      (item),
    .job_valid (job_push),
    .job_full  (job_full),
    .job       (job_in)
  );

  arpn_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .empty   (job_empty)
  );

  // The back end divides the scaled distance by the range and saturates.
  arpn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

[dv/tb_auto_ranging_pulse_normalizer_unit.sv]
// ---------------------------------------------------------------------------
// tb_auto_ranging_pulse_normalizer_unit: self-checking bench for the normalizer
// Drives measurement words through the push/full port and pops results, while
// a local bound tracker predicts each result. The run walks through several
// floor and span settings with random idling on both sides and one long hold
// on the result side. It ends with a single pass or fail line.
// ---------------------------------------------------------------------------
module tb_auto_ranging_pulse_normalizer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes that the block does not implement; writes must be ignored.
  localparam logic [arpn_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [arpn_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  // Settling time for a drained block.
  localparam int SETTLE_CYCLES    = 64;
  // Long stretch in which the result side refuses every word.
  localparam int HOLD_OFF_CYCLES  = 400;
  // Cycles without any accepted word before the run is declared hung.
  localparam int QUIET_LIMIT      = 5000;
  localparam int MAX_REPORTS      = 10;
  localparam int WORDS_PER_PHASE  = 250;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_we    = 1'b0;
  logic [arpn_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [arpn_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                            push      = 1'b0;
  logic                            full;
  arpn_pkg::in_word_t              item      = '0;
  logic                            empty;
  logic                            pop       = 1'b0;
  arpn_pkg::out_word_t             result;

  auto_ranging_pulse_normalizer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Words waiting to be offered, and results predicted for accepted words.
  arpn_pkg::in_word_t  pending_words[$];
  arpn_pkg::out_word_t expected_results[$];

  // Local copy of the per-channel bounds and the two registers.
  logic [15:0] bound_low  [arpn_pkg::NUM_CHANNELS];
  logic [15:0] bound_high [arpn_pkg::NUM_CHANNELS];
  logic [15:0] floor_setting;
  logic [9:0]  span_setting;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned mismatch_count = 0;

  // Updates the bounds of the word's channel and maps the width onto them.
  // An unknown channel or a range that is empty or inverted gives percent 0
  // with the invalid flag set; otherwise the quotient truncates toward zero
  // and saturates to the signed 16-bit range.
  function automatic arpn_pkg::out_word_t predict_normalized(arpn_pkg::in_word_t word);
    arpn_pkg::out_word_t res;
    logic [15:0]         lo;
    logic [15:0]         hi;
    longint              num;
    longint              quo;
    res.channel_out   = word.channel;
    res.percent       = '0;
    res.range_invalid = 1'b1;
    if (word.channel < arpn_pkg::NUM_CHANNELS) begin
      if (word.pulse_width > floor_setting && word.pulse_width < bound_low[word.channel]) begin
        bound_low[word.channel] = word.pulse_width;
      end
      if (word.pulse_width > bound_high[word.channel]) begin
        bound_high[word.channel] = word.pulse_width;
      end
      lo = bound_low[word.channel];
      hi = bound_high[word.channel];
      if (hi > lo) begin
        num = (longint'(word.pulse_width) - longint'(lo)) * longint'(span_setting);
        quo = num / (longint'(hi) - longint'(lo));
        if (quo > 32767) begin
          quo = 32767;
        end else if (quo < -32768) begin
          quo = -32768;
        end
        res.percent       = 16'(quo);
        res.range_invalid = 1'b0;
      end
    end
    return res;
  endfunction

  // Random measurement: mostly real channels, widths spread over the whole
  // range, the low end around the floor, the extremes, and values close to
  // the current bounds so that the compare edges get exercised.
  function automatic arpn_pkg::in_word_t random_word();
    arpn_pkg::in_word_t word;
    int unsigned        pick;
    logic [15:0]        base;
    pick = $urandom_range(99);
    if (pick < 10) begin
      word.channel = 3'($urandom_range(7, arpn_pkg::NUM_CHANNELS));
    end else begin
      word.channel = 3'($urandom_range(arpn_pkg::NUM_CHANNELS - 1));
    end
    pick = $urandom_range(99);
    if (pick < 45) begin
      word.pulse_width = 16'($urandom_range(65535));
    end else if (pick < 65) begin
      word.pulse_width = 16'($urandom_range(1200));
    end else if (pick < 80) begin
      case ($urandom_range(3))
        0:       word.pulse_width = 16'h0000;
        1:       word.pulse_width = 16'hFFFF;
        2:       word.pulse_width = floor_setting;
        default: word.pulse_width = floor_setting + 16'd1;
      endcase
    end else if (word.channel < arpn_pkg::NUM_CHANNELS) begin
      base = ($urandom_range(1) != 0) ? bound_low[word.channel] : bound_high[word.channel];
      word.pulse_width = base + 16'($urandom_range(8)) - 16'd4;
    end else begin
      word.pulse_width = 16'($urandom_range(65535));
    end
    return word;
  endfunction

  // Register write; the block is idle whenever this is called, so the local
  // copy can follow right away. Only the low ten bits reach the span.
  task automatic write_register(input logic [arpn_pkg::CFG_IDX_W-1:0] idx,
                                input logic [arpn_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      arpn_pkg::REG_VALID_FLOOR: floor_setting = data;
      arpn_pkg::REG_OUT_SPAN:    span_setting  = data[9:0];
      default: ;
    endcase
  endtask

  task automatic add_word(input logic [2:0] ch, input logic [15:0] width);
    arpn_pkg::in_word_t word;
    word.channel     = ch;
    word.pulse_width = width;
    pending_words.push_back(word);
  endtask

  // Waits until every word went in and every result came out, then lets the
  // back end settle before the next register write.
  task automatic drain();
    while (pending_words.size() != 0 || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle,
                           input bit with_hold);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (WORDS_PER_PHASE) pending_words.push_back(random_word());
    if (with_hold) begin
      hold_requests++;
    end
    drain();
  endtask

  // Sender: offers the oldest pending word unless it decides to idle. While
  // push is low the data lines carry junk that the block must ignore.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      push <= 1'b1;
      item <= pending_words[0];
    end else begin
      push <= 1'b0;
      item <= arpn_pkg::in_word_t'(19'($urandom));
    end
  end

  // Receiver: pops at random, except during a requested hold-off, which it
  // counts down itself so the sender keeps pushing until the block is full.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      pop         <= 1'b0;
      hold_left   <= HOLD_OFF_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: at each rising edge an accepted input word is predicted and an
  // accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin
    arpn_pkg::out_word_t want;
    bit                  moved;
    moved = 1'b0;
    if (!rst) begin
      if (push && !full) begin
        expected_results.push_back(predict_normalized(item));
        void'(pending_words.pop_front());
        moved = 1'b1;
      end
      if (pop && !empty) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: result ch %0d pct %0d inv %0b with nothing expected",
                     $realtime, result.channel_out, result.percent, result.range_invalid);
          end
        end else begin
          want = expected_results.pop_front();
          if (result.channel_out !== want.channel_out || result.percent !== want.percent ||
              result.range_invalid !== want.range_invalid) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: expected ch %0d pct %0d inv %0b, got ch %0d pct %0d inv %0b",
                       $realtime, want.channel_out, want.percent, want.range_invalid,
                       result.channel_out, result.percent, result.range_invalid);
            end
          end
        end
      end
    end
    quiet_cycles = (rst || moved) ? 0 : quiet_cycles + 1;
  end

  // Watchdog: a long stretch with no accepted word in either direction means
  // the block has hung.
  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < arpn_pkg::NUM_CHANNELS; c++) begin
      bound_low[c]  = arpn_pkg::LOW_RESET;
      bound_high[c] = '0;
    end
    floor_setting = arpn_pkg::FLOOR_RESET;
    span_setting  = arpn_pkg::SPAN_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words on fresh bounds with the default floor and span.
    send_idle_pct = 37;
    recv_idle_pct = 86;
    add_word(3'd0, 16'd0);       // below the floor with no high bound: empty range
    add_word(3'd0, 16'd5000);    // high equals low: still an empty range
    add_word(3'd0, 16'd5010);    // width at the high bound gives the full span
    add_word(3'd0, 16'd0);       // far below a narrow range: saturates negative
    add_word(3'd0, 16'd4999);    // lowers the low bound, maps to zero
    add_word(3'd1, 16'hFFFF);    // widest possible width
    add_word(3'd1, 16'd501);     // just above the floor lowers the low bound
    add_word(3'd1, 16'd500);     // at the floor: small negative truncates to zero
    add_word(3'd1, 16'd32768);
    add_word(3'd2, 16'hFFFF);
    add_word(3'd3, 16'd1);       // high below low: inverted range
    add_word(3'd6, 16'd7000);    // unknown channels leave all bounds alone
    add_word(3'd7, 16'hFFFF);
    add_word(3'd5, 16'hAAAA);
    add_word(3'd5, 16'h5555);
    add_word(3'd4, 16'd600);
    add_word(3'd4, 16'd4000);
    drain();

    // Floor at zero, smallest span, and a write to an unimplemented index.
    write_register(arpn_pkg::REG_VALID_FLOOR, 16'h0000);
    write_register(arpn_pkg::REG_OUT_SPAN, 16'h0001);
    write_register(REG_UNUSED_2, 16'hFFFF);
    run_phase(37, 86, 1'b0);

    // Highest floor: low bounds freeze; largest stated span.
    write_register(arpn_pkg::REG_VALID_FLOOR, 16'hFFFF);
    write_register(arpn_pkg::REG_OUT_SPAN, 16'd1000);
    run_phase(37, 86, 1'b0);

    // All data bits set: span beyond its stated range.
    write_register(arpn_pkg::REG_VALID_FLOOR, 16'($urandom_range(65535)));
    write_register(arpn_pkg::REG_OUT_SPAN, 16'hFFFF);
    run_phase(86, 37, 1'b0);

    // Only bits above the span field set: span of zero.
    write_register(arpn_pkg::REG_VALID_FLOOR, 16'd1000);
    write_register(arpn_pkg::REG_OUT_SPAN, 16'h0400);
    write_register(REG_UNUSED_3, 16'($urandom_range(65535)));
    run_phase(86, 37, 1'b0);

    // No idling, with one long hold on the result side to fill the block.
    write_register(arpn_pkg::REG_VALID_FLOOR, 16'($urandom_range(4000)));
    write_register(arpn_pkg::REG_OUT_SPAN,
                   {6'($urandom_range(63)), 10'($urandom_range(1000, 1))});
    run_phase(0, 0, 1'b1);

    write_register(arpn_pkg::REG_VALID_FLOOR, arpn_pkg::FLOOR_RESET);
    write_register(arpn_pkg::REG_OUT_SPAN, 16'(arpn_pkg::SPAN_RESET));
    run_phase(0, 0, 1'b0);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
